/* sv/lfsm_pkg.sv */
// ----------------------------------------------------------------------------
// lfsm_pkg - latest frame slot manager shared definitions
// widths, slot count and command codes used by the block and its checker
// ----------------------------------------------------------------------------
package lfsm_pkg;

	localparam int SLOTS   = 3;
	localparam int SLOT_W  = 2;
	localparam int STAMP_W = 64;
	localparam int CNT_W   = 32;
	// enough bits to count every slot
	localparam int NCNT_W  = $clog2(SLOTS + 1);

	localparam int IN_W  = 8;
	localparam int OUT_W = 72;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] CMD_PUBLISH = 2'd0;
	localparam logic [1:0] CMD_TAKE    = 2'd1;
	localparam logic [1:0] CMD_FINISH  = 2'd2;
	localparam logic [1:0] CMD_READ    = 2'd3;

endpackage

/* sv/latest_frame_slot_manager_top.sv */
// ----------------------------------------------------------------------------
// latest_frame_slot_manager_top - frame buffer slot manager
// hands out producer and consumer slots, keeps sent and dropped counters
// ----------------------------------------------------------------------------
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+------------------------------------
// s_*      | in  | s_tvalid/s_tready  | s_tdata: cmd, done_slot, send_ok
// m_*      | out | m_tvalid/m_tready  | m_tdata: granted, grant_slot,
//          |     |                    |          sent_total, dropped_total
//
// one beat in gives exactly one beat out, in order
// a command beat is registered in the input register, then decoded against the
// slot state by combinational logic and the result lands in the output register,
// so the block sustains one beat per cycle while m_tready does not stall results
// the stamp comparators (one per ordered slot pair) and the 64-bit stamp
// increment set the depth of that decode logic
// arst_n clears all slot bits, stamps and counters; no warm-up sweep
// a stalled result holds the output register; the input register still
// takes a beat while it is empty
// ----------------------------------------------------------------------------
module latest_frame_slot_manager_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [1:0] cmd, [3:2] done_slot, [4] send_ok, [7:5] zero
	input  logic [lfsm_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] granted, [2:1] grant_slot, [34:3] sent_total,
	// [66:35] dropped_total, [71:67] zero
	output logic [lfsm_pkg::OUT_W-1:0]  m_tdata
);

	// saturating counter add
	function automatic logic [lfsm_pkg::CNT_W-1:0] sat_add(
		input logic [lfsm_pkg::CNT_W-1:0]  a,
		input logic [lfsm_pkg::NCNT_W-1:0] b
	);
		logic [lfsm_pkg::CNT_W:0] sum;
		sum = {1'b0, a} + (lfsm_pkg::CNT_W + 1)'(b);
		return sum[lfsm_pkg::CNT_W] ? lfsm_pkg::CNT_MAX : sum[lfsm_pkg::CNT_W-1:0];
	endfunction

	// input register
	logic                          valid_s1;
	logic [1:0]                    cmd_s1;
	logic [lfsm_pkg::SLOT_W-1:0]   done_slot_s1;
	logic                          send_ok_s1;

	// result register
	logic                          valid_s2;
	logic                          granted_s2;
	logic [lfsm_pkg::SLOT_W-1:0]   grant_slot_s2;
	logic [lfsm_pkg::CNT_W-1:0]    sent_total_s2;
	logic [lfsm_pkg::CNT_W-1:0]    dropped_total_s2;

	// slot state
	logic [lfsm_pkg::SLOTS-1:0]    filled_q;
	logic [lfsm_pkg::SLOTS-1:0]    sending_q;
	logic [lfsm_pkg::STAMP_W-1:0]  stamp_q [lfsm_pkg::SLOTS];
	logic [lfsm_pkg::STAMP_W-1:0]  frame_stamp_q;
	logic [lfsm_pkg::CNT_W-1:0]    sent_q;
	logic [lfsm_pkg::CNT_W-1:0]    dropped_q;

	// next state
	logic [lfsm_pkg::SLOTS-1:0]    filled_d;
	logic [lfsm_pkg::SLOTS-1:0]    sending_d;
	logic [lfsm_pkg::STAMP_W-1:0]  stamp_d [lfsm_pkg::SLOTS];
	logic [lfsm_pkg::STAMP_W-1:0]  frame_stamp_d;
	logic [lfsm_pkg::CNT_W-1:0]    sent_upd;
	logic [lfsm_pkg::CNT_W-1:0]    dropped_upd;
	logic [lfsm_pkg::CNT_W-1:0]    sent_d;
	logic [lfsm_pkg::CNT_W-1:0]    dropped_d;
	logic                          granted_d;
	logic [lfsm_pkg::SLOT_W-1:0]   grant_slot_d;

	// selection
	logic [lfsm_pkg::SLOTS-1:0]    lt [lfsm_pkg::SLOTS];
	logic [lfsm_pkg::SLOTS-1:0]    cand_pub;
	logic [lfsm_pkg::SLOTS-1:0]    cand_take;
	logic [lfsm_pkg::SLOTS-1:0]    pick_pub;
	logic [lfsm_pkg::SLOTS-1:0]    pick_take;
	logic [lfsm_pkg::SLOT_W-1:0]   idx_pub;
	logic [lfsm_pkg::SLOT_W-1:0]   idx_take;
	logic [lfsm_pkg::NCNT_W-1:0]   n_take;
	logic [lfsm_pkg::NCNT_W-1:0]   n_others;
	logic [lfsm_pkg::STAMP_W-1:0]  stamp_inc;

	logic advance;

	// the result register moves when empty or drained this cycle
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// pairwise stamp compare, lt[i][j] means slot i older than slot j
	always_comb begin
		for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
			for (int j = 0; j < lfsm_pkg::SLOTS; j++) begin
				lt[i][j] = (i != j) && (stamp_q[i] < stamp_q[j]);
			end
		end
	end

	// oldest free slot and newest waiting slot, ties to the lowest index
	always_comb begin
		cand_pub  = ~filled_q & ~sending_q;
		cand_take = filled_q & ~sending_q;
		idx_pub   = '0;
		idx_take  = '0;
		n_take    = '0;
		for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
			pick_pub[i]  = cand_pub[i];
			pick_take[i] = cand_take[i];
			for (int j = 0; j < lfsm_pkg::SLOTS; j++) begin
				if (j < i) begin
					// lower index wins ties, so strictly better needed
					if (cand_pub[j] && !lt[i][j])
						pick_pub[i] = 1'b0;
					if (cand_take[j] && !lt[j][i])
						pick_take[i] = 1'b0;
				end else if (j > i) begin
					if (cand_pub[j] && lt[j][i])
						pick_pub[i] = 1'b0;
					if (cand_take[j] && lt[i][j])
						pick_take[i] = 1'b0;
				end
			end
			n_take = n_take + lfsm_pkg::NCNT_W'(cand_take[i]);
		end
		for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
			if (pick_pub[i])
				idx_pub = idx_pub | lfsm_pkg::SLOT_W'(i);
			if (pick_take[i])
				idx_take = idx_take | lfsm_pkg::SLOT_W'(i);
		end
		// every waiting frame but the one taken is dropped
		n_others = (n_take == '0) ? '0 : n_take - lfsm_pkg::NCNT_W'(1);
	end

	assign stamp_inc = frame_stamp_q + lfsm_pkg::STAMP_W'(1);

	// command decode and state update
	always_comb begin
		filled_d      = filled_q;
		sending_d     = sending_q;
		stamp_d       = stamp_q;
		frame_stamp_d = frame_stamp_q;
		sent_upd      = sent_q;
		dropped_upd   = dropped_q;
		granted_d     = 1'b0;
		grant_slot_d  = '0;
		unique case (cmd_s1)
			lfsm_pkg::CMD_PUBLISH: begin
				if (|pick_pub) begin
					frame_stamp_d = stamp_inc;
					for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
						if (pick_pub[i]) begin
							stamp_d[i]  = stamp_inc;
							filled_d[i] = 1'b1;
						end
					end
					granted_d    = 1'b1;
					grant_slot_d = idx_pub;
				end else begin
					// producer finds no free slot, frame lost
					dropped_upd = sat_add(dropped_q, lfsm_pkg::NCNT_W'(1));
				end
			end
			lfsm_pkg::CMD_TAKE: begin
				if (|pick_take) begin
					for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
						if (pick_take[i])
							sending_d[i] = 1'b1;
						else if (cand_take[i])
							filled_d[i] = 1'b0;
					end
					dropped_upd  = sat_add(dropped_q, n_others);
					granted_d    = 1'b1;
					grant_slot_d = idx_take;
				end
			end
			lfsm_pkg::CMD_FINISH: begin
				// out-of-range or idle slot falls through untouched
				for (int i = 0; i < lfsm_pkg::SLOTS; i++) begin
					if (int'(done_slot_s1) == i && sending_q[i]) begin
						sending_d[i] = 1'b0;
						filled_d[i]  = 1'b0;
						if (send_ok_s1)
							sent_upd = sat_add(sent_q, lfsm_pkg::NCNT_W'(1));
						else
							dropped_upd = sat_add(dropped_q, lfsm_pkg::NCNT_W'(1));
					end
				end
			end
			lfsm_pkg::CMD_READ: begin
				// counters reported below, then cleared
			end
			default: begin
			end
		endcase
		sent_d    = (cmd_s1 == lfsm_pkg::CMD_READ) ? '0 : sent_upd;
		dropped_d = (cmd_s1 == lfsm_pkg::CMD_READ) ? '0 : dropped_upd;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1       <= s_tdata[1:0];
			done_slot_s1 <= s_tdata[3:2];
			send_ok_s1   <= s_tdata[4];
		end
	end

	// slot state, updated once per decoded beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q      <= '0;
			sending_q     <= '0;
			frame_stamp_q <= '0;
			sent_q        <= '0;
			dropped_q     <= '0;
			for (int i = 0; i < lfsm_pkg::SLOTS; i++)
				stamp_q[i] <= '0;
		end else if (advance) begin
			filled_q      <= filled_d;
			sending_q     <= sending_d;
			frame_stamp_q <= frame_stamp_d;
			sent_q        <= sent_d;
			dropped_q     <= dropped_d;
			stamp_q       <= stamp_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			granted_s2       <= granted_d;
			grant_slot_s2    <= grant_slot_d;
			// counters after this beat's update, before a read clear
			sent_total_s2    <= sent_upd;
			dropped_total_s2 <= dropped_upd;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, dropped_total_s2, sent_total_s2, grant_slot_s2, granted_s2};

endmodule

/* sv/lfsm_checker.sv */
// ----------------------------------------------------------------------------
// lfsm_checker - port-level checks for the frame slot manager
// watches the result channel and the input ready over time
// ----------------------------------------------------------------------------
module lfsm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [lfsm_pkg::OUT_W-1:0]  m_tdata
);

	// a stalled result beat stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// and keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// with an empty result register the input side never stalls
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

	// no grant reports slot zero
	a_nogrant_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'd0)
		else $error("slot reported without a grant");

	// a grant names an existing slot
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> int'(m_tdata[2:1]) < lfsm_pkg::SLOTS)
		else $error("granted slot out of range");

endmodule

bind latest_frame_slot_manager_top lfsm_checker u_lfsm_checker (.*);
